@@ sv/rotation_vector_to_matrix_top_defines.svh @@
// Assertion macros for the rotation matrix block.
`ifndef ROTATION_VECTOR_TO_MATRIX_TOP_DEFINES_SVH
`define ROTATION_VECTOR_TO_MATRIX_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define RV2M_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RV2M_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rv2m_pkg.sv @@
package rv2m_pkg;

    localparam int PHI_W             = 18;
    localparam int OUT_W             = 18;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_OUT_FRAC_BITS = 16;
    localparam int ATAN_LEN          = 24;
    localparam int SQRT_BITS         = 31;
    localparam int QUO_BITS          = 31;

    localparam logic [33:0]        TWO_PI2_Q30 = 34'd13493037704;
    localparam logic [33:0]        TWO_PI_Q30  = 34'd6746518852;
    localparam logic signed [34:0] TWO_PI_S    = 35'sd6746518852;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] ONE_Q30     = 35'sd1073741824;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    // atan(2^-i) in Q.30, truncated
    function automatic logic signed [34:0] atan_q30(input int i);
        case (i)
            0:  return 35'sd843314856;
            1:  return 35'sd497837829;
            2:  return 35'sd263043836;
            3:  return 35'sd133525158;
            4:  return 35'sd67021686;
            5:  return 35'sd33543515;
            6:  return 35'sd16775850;
            7:  return 35'sd8388437;
            8:  return 35'sd4194282;
            9:  return 35'sd2097149;
            10: return 35'sd1048575;
            11: return 35'sd524287;
            12: return 35'sd262143;
            13: return 35'sd131071;
            14: return 35'sd65535;
            15: return 35'sd32767;
            16: return 35'sd16383;
            17: return 35'sd8191;
            18: return 35'sd4095;
            19: return 35'sd2047;
            20: return 35'sd1023;
            21: return 35'sd511;
            22: return 35'sd255;
            23: return 35'sd127;
            default: return 35'sd0;
        endcase
    endfunction

endpackage

@@ sv/rotation_vector_to_matrix_top.sv @@
// Rotation vector (Q3.14) to 3x3 rotation matrix (Q1.16 by default) by the Rodrigues
// formula. One vector is taken per clock. The datapath is built around the pipelined
// 31-step square root and the 31-step long divide that forms the unit axis
// (sine and cosine come from a CORDIC chain that runs alongside the divide). Entries are
// row-major in m_tdata, rounded and saturated; a zero vector gives the identity. The input
// stalls only while the output register and its one-word skid stage are both full.
`include "rotation_vector_to_matrix_top_defines.svh"

module rotation_vector_to_matrix_top
    import rv2m_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
    parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // phi_x, phi_y, phi_z, pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata    // r00 r01 r02 r10 r11 r12 r20 r21 r22, pad
);

    localparam int NCS = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int DLY = 28 - NCS;
    localparam int SH  = 60 - OUT_FRAC_BITS;
    localparam logic signed [68:0] HALF_RND = 69'sd1 <<< (SH - 1);
    localparam logic signed [68:0] ONE_Q60  = 69'sd1 <<< 60;
    localparam logic signed [68:0] OUT_MAX  = 69'sd131071;
    localparam logic signed [68:0] OUT_MIN  = -69'sd131072;

    logic en;
    logic skid_valid_reg;
    logic m_tvalid_reg;
    logic [167:0] m_tdata_reg;
    logic [167:0] skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- input, squares, sum ----------------
    logic                    a_v_reg;
    logic signed [PHI_W-1:0] a_p_reg [3];
    logic                    b_v_reg;
    logic signed [PHI_W-1:0] b_p_reg [3];
    logic [34:0]             sqr_reg [3];
    logic signed [71:0]      sqr_full [3];
    logic [35:0]             sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= s_tvalid;
            b_v_reg <= a_v_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sqr_full[i] = 72'(a_p_reg[i]) * 72'(a_p_reg[i]);
        end
        sum_next = 36'(sqr_reg[0]) + 36'(sqr_reg[1]) + 36'(sqr_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_p_reg[0] <= s_tdata[17:0];
            a_p_reg[1] <= s_tdata[35:18];
            a_p_reg[2] <= s_tdata[53:36];
            for (int i = 0; i < 3; i++)
            begin
                b_p_reg[i] <= a_p_reg[i];
                sqr_reg[i] <= sqr_full[i][34:0];
            end
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic                    sq_v_reg    [0:SQRT_BITS];
    logic                    sq_zero_reg [0:SQRT_BITS];
    logic [63:0]             sq_rem_reg  [0:SQRT_BITS];
    logic [SQRT_BITS-1:0]    sq_root_reg [0:SQRT_BITS];
    logic signed [PHI_W-1:0] sq_p_reg    [0:SQRT_BITS][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else if (en)
            sq_v_reg[0] <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rem_reg[0]  <= 64'(sum_next) << 26;
            sq_root_reg[0] <= '0;
            sq_zero_reg[0] <= (sum_next == '0);
            sq_p_reg[0]    <= b_p_reg;
        end
    end

    for (genvar k = 0; k < SQRT_BITS; k++)
    begin : g_sqrt
        localparam int B = SQRT_BITS - 1 - k;
        logic [63:0] trial;

        assign trial = (64'(sq_root_reg[k]) << (B + 1)) + (64'd1 << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else if (en)
                sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sq_rem_reg[k] >= trial)
                begin
                    sq_rem_reg[k+1]  <= sq_rem_reg[k] - trial;
                    sq_root_reg[k+1] <= sq_root_reg[k] | (SQRT_BITS'(1) << B);
                end
                else
                begin
                    sq_rem_reg[k+1]  <= sq_rem_reg[k];
                    sq_root_reg[k+1] <= sq_root_reg[k];
                end
                sq_zero_reg[k+1] <= sq_zero_reg[k];
                sq_p_reg[k+1]    <= sq_p_reg[k];
            end
        end
    end

    logic [SQRT_BITS-1:0] norm;
    assign norm = sq_root_reg[SQRT_BITS];

    // ---------------- axis: three long dividers ----------------
    logic                 dv_v_reg    [0:QUO_BITS];
    logic                 dv_zero_reg [0:QUO_BITS];
    logic [SQRT_BITS-1:0] dv_norm_reg [0:QUO_BITS];
    logic [63:0]          dv_rem_reg  [0:QUO_BITS][3];
    logic [QUO_BITS-1:0]  dv_q_reg    [0:QUO_BITS][3];
    logic                 dv_neg_reg  [0:QUO_BITS][3];
    logic [PHI_W-1:0]     mag_next    [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = sq_p_reg[SQRT_BITS][i][PHI_W-1] ? PHI_W'(-sq_p_reg[SQRT_BITS][i])
                                                          : PHI_W'(sq_p_reg[SQRT_BITS][i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (en)
            dv_v_reg[0] <= sq_v_reg[SQRT_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_zero_reg[0] <= sq_zero_reg[SQRT_BITS];
            dv_norm_reg[0] <= norm;
            for (int i = 0; i < 3; i++)
            begin
                // round to nearest: add half the divisor up front
                dv_rem_reg[0][i] <= (64'(mag_next[i]) << 43) + 64'(norm >> 1);
                dv_q_reg[0][i]   <= '0;
                dv_neg_reg[0][i] <= sq_p_reg[SQRT_BITS][i][PHI_W-1];
            end
        end
    end

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_div
        localparam int B = QUO_BITS - 1 - k;
        logic [63:0] dsh;

        assign dsh = 64'(dv_norm_reg[k]) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[k+1] <= 1'b0;
            else if (en)
                dv_v_reg[k+1] <= dv_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (dv_rem_reg[k][i] >= dsh)
                    begin
                        dv_rem_reg[k+1][i] <= dv_rem_reg[k][i] - dsh;
                        dv_q_reg[k+1][i]   <= dv_q_reg[k][i] | (QUO_BITS'(1) << B);
                    end
                    else
                    begin
                        dv_rem_reg[k+1][i] <= dv_rem_reg[k][i];
                        dv_q_reg[k+1][i]   <= dv_q_reg[k][i];
                    end
                    dv_neg_reg[k+1][i] <= dv_neg_reg[k][i];
                end
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                dv_norm_reg[k+1] <= dv_norm_reg[k];
            end
        end
    end

    logic               u_v_reg;
    logic               u_zero_reg;
    logic signed [31:0] u_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            u_v_reg <= 1'b0;
        else if (en)
            u_v_reg <= dv_v_reg[QUO_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_zero_reg <= dv_zero_reg[QUO_BITS];
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= dv_neg_reg[QUO_BITS][i] ? -$signed({1'b0, dv_q_reg[QUO_BITS][i]})
                                                    :  $signed({1'b0, dv_q_reg[QUO_BITS][i]});
            end
        end
    end

    // ---------------- angle path, lined up with the divider ----------------
    logic [SQRT_BITS-1:0] nd_reg [DLY];
    logic [33:0]          ra1_reg;
    logic [32:0]          ra2_reg;
    logic signed [34:0]   ra3_reg;
    logic [33:0]          ang;

    assign ang = {nd_reg[DLY-1], 3'b000};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nd_reg[0] <= norm;
            for (int i = 1; i < DLY; i++)
            begin
                nd_reg[i] <= nd_reg[i-1];
            end
            ra1_reg <= (ang >= TWO_PI2_Q30) ? ang - TWO_PI2_Q30 : ang;
            ra2_reg <= (ra1_reg >= TWO_PI_Q30) ? 33'(ra1_reg - TWO_PI_Q30) : ra1_reg[32:0];
            ra3_reg <= ($signed({2'b00, ra2_reg}) > PI_Q30) ? $signed({2'b00, ra2_reg}) - TWO_PI_S
                                                           : $signed({2'b00, ra2_reg});
        end
    end

    logic signed [33:0] cr_x_reg   [0:NCS];
    logic signed [33:0] cr_y_reg   [0:NCS];
    logic signed [34:0] cr_z_reg   [0:NCS];
    logic               cr_neg_reg [0:NCS];

    // fold into [-pi/2, pi/2]; a half-turn flips both sine and cosine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cr_x_reg[0] <= GAIN_Q30;
            cr_y_reg[0] <= '0;
            if (ra3_reg > HALF_PI_Q30)
            begin
                cr_z_reg[0]   <= ra3_reg - PI_Q30;
                cr_neg_reg[0] <= 1'b1;
            end
            else if (ra3_reg < -HALF_PI_Q30)
            begin
                cr_z_reg[0]   <= ra3_reg + PI_Q30;
                cr_neg_reg[0] <= 1'b1;
            end
            else
            begin
                cr_z_reg[0]   <= ra3_reg;
                cr_neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < NCS; i++)
    begin : g_cordic
        localparam logic signed [34:0] ATN = atan_q30(i);
        logic signed [33:0] dx;
        logic signed [33:0] dy;

        assign dx = cr_y_reg[i] >>> i;
        assign dy = cr_x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!cr_z_reg[i][34])
                begin
                    cr_x_reg[i+1] <= cr_x_reg[i] - dx;
                    cr_y_reg[i+1] <= cr_y_reg[i] + dy;
                    cr_z_reg[i+1] <= cr_z_reg[i] - ATN;
                end
                else
                begin
                    cr_x_reg[i+1] <= cr_x_reg[i] + dx;
                    cr_y_reg[i+1] <= cr_y_reg[i] - dy;
                    cr_z_reg[i+1] <= cr_z_reg[i] + ATN;
                end
                cr_neg_reg[i+1] <= cr_neg_reg[i];
            end
        end
    end

    logic signed [33:0] sn_reg;
    logic signed [34:0] omc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn_reg  <= cr_neg_reg[NCS] ? -cr_y_reg[NCS] : cr_y_reg[NCS];
            omc_reg <= cr_neg_reg[NCS] ? ONE_Q30 + 35'(cr_x_reg[NCS])
                                       : ONE_Q30 - 35'(cr_x_reg[NCS]);
        end
    end

    // ---------------- matrix assembly ----------------
    // uu order: xx yy zz xy xz yz
    logic               m1_v_reg, m2_v_reg, m3_v_reg, m4_v_reg, t_v_reg;
    logic               m1_zero_reg, m2_zero_reg, m3_zero_reg;
    logic signed [63:0] uu_reg   [6];
    logic signed [31:0] m1_u_reg [3];
    logic signed [31:0] m2_u_reg [3];
    logic signed [33:0] m1_sn_reg, m2_sn_reg;
    logic signed [34:0] m1_omc_reg, m2_omc_reg;
    logic signed [32:0] kk_reg   [6];
    logic signed [65:0] snu_reg  [3];
    logic signed [67:0] omkk_reg [6];
    logic signed [68:0] acc_reg  [9];
    logic signed [17:0] res_reg  [9];
    logic signed [63:0] kk_sum   [6];
    logic signed [63:0] kk_rnd   [6];

    always_comb
    begin
        kk_sum[0] = -(uu_reg[1] + uu_reg[2]);
        kk_sum[1] = -(uu_reg[2] + uu_reg[0]);
        kk_sum[2] = -(uu_reg[0] + uu_reg[1]);
        kk_sum[3] = uu_reg[3];
        kk_sum[4] = uu_reg[4];
        kk_sum[5] = uu_reg[5];
        for (int i = 0; i < 6; i++)
        begin
            kk_rnd[i] = (kk_sum[i] + 64'sd536870912) >>> 30;
        end
    end

    function automatic logic signed [17:0] round_sat(input logic signed [68:0] a);
        logic signed [68:0] t;
        t = (a + HALF_RND) >>> SH;
        if (t > OUT_MAX)
            return OUT_MAX[17:0];
        else if (t < OUT_MIN)
            return OUT_MIN[17:0];
        return t[17:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
            m4_v_reg <= 1'b0;
            t_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            m1_v_reg <= u_v_reg;
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
            m4_v_reg <= m3_v_reg;
            t_v_reg  <= m4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uu_reg[0]   <= u_reg[0] * u_reg[0];
            uu_reg[1]   <= u_reg[1] * u_reg[1];
            uu_reg[2]   <= u_reg[2] * u_reg[2];
            uu_reg[3]   <= u_reg[0] * u_reg[1];
            uu_reg[4]   <= u_reg[0] * u_reg[2];
            uu_reg[5]   <= u_reg[1] * u_reg[2];
            m1_u_reg    <= u_reg;
            m1_sn_reg   <= sn_reg;
            m1_omc_reg  <= omc_reg;
            m1_zero_reg <= u_zero_reg;

            for (int i = 0; i < 6; i++)
            begin
                kk_reg[i] <= kk_rnd[i][32:0];
            end
            m2_u_reg    <= m1_u_reg;
            m2_sn_reg   <= m1_sn_reg;
            m2_omc_reg  <= m1_omc_reg;
            m2_zero_reg <= m1_zero_reg;

            for (int i = 0; i < 3; i++)
            begin
                snu_reg[i] <= 66'(m2_sn_reg) * 66'(m2_u_reg[i]);
            end
            for (int i = 0; i < 6; i++)
            begin
                omkk_reg[i] <= 68'(m2_omc_reg) * 68'(kk_reg[i]);
            end
            m3_zero_reg <= m2_zero_reg;

            if (m3_zero_reg)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    acc_reg[i] <= (i % 4 == 0) ? ONE_Q60 : '0;
                end
            end
            else
            begin
                acc_reg[0] <= ONE_Q60 + 69'(omkk_reg[0]);
                acc_reg[1] <= 69'(omkk_reg[3]) - 69'(snu_reg[2]);
                acc_reg[2] <= 69'(omkk_reg[4]) + 69'(snu_reg[1]);
                acc_reg[3] <= 69'(omkk_reg[3]) + 69'(snu_reg[2]);
                acc_reg[4] <= ONE_Q60 + 69'(omkk_reg[1]);
                acc_reg[5] <= 69'(omkk_reg[5]) - 69'(snu_reg[0]);
                acc_reg[6] <= 69'(omkk_reg[4]) - 69'(snu_reg[1]);
                acc_reg[7] <= 69'(omkk_reg[5]) + 69'(snu_reg[0]);
                acc_reg[8] <= ONE_Q60 + 69'(omkk_reg[2]);
            end

            for (int i = 0; i < 9; i++)
            begin
                res_reg[i] <= round_sat(acc_reg[i]);
            end
        end
    end

    // ---------------- output register and skid word ----------------
    logic [167:0] tail_data;

    assign tail_data = {6'b000000, res_reg[8], res_reg[7], res_reg[6], res_reg[5], res_reg[4],
                        res_reg[3], res_reg[2], res_reg[1], res_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
                skid_valid_reg <= 1'b0;
        end
        else if (!m_tvalid_reg || m_tready)
            m_tvalid_reg <= t_v_reg;
        else if (t_v_reg)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
                m_tdata_reg <= skid_data_reg;
        end
        else if (!m_tvalid_reg || m_tready)
            m_tdata_reg <= tail_data;
        else
            skid_data_reg <= tail_data;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `RV2M_ASSERT_IMPL(a_skid_has_out, skid_valid_reg, m_tvalid_reg, "skid word without output word")
    `RV2M_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !m_tready, skid_valid_reg, "skid word dropped")
    `RV2M_ASSERT_IMPL(a_skid_cause, $rose(skid_valid_reg), $past(m_tvalid_reg && !m_tready && t_v_reg), "skid filled without a stall")

endmodule

@@ verif/tb_rotation_vector_to_matrix_top.sv @@
`timescale 1ns / 100ps

module tb_rotation_vector_to_matrix_top;
    import rv2m_pkg::*;

    typedef logic [8:0][17:0] matrix_t;
    typedef struct packed
    {
        logic [17:0] z;
        logic [17:0] y;
        logic [17:0] x;
    } rotvec_t;

    localparam int  STAGES     = DEF_CORDIC_STAGES;
    localparam int  FRAC       = DEF_OUT_FRAC_BITS;
    localparam int  STALL_MAX  = 3000;
    localparam int  DRAIN_WAIT = 120;

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [55:0]    s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [167:0]   m_tdata;

    rotvec_t        vec_queue[$];
    matrix_t        matrix_queue[$];
    int             send_idle_pct;
    int             recv_idle_pct;
    int             recv_hold;
    int             mismatches = 0;
    int             stall_cycles;
    logic           in_taken;
    logic           hold_req;
    logic           hold_done;

    rotation_vector_to_matrix_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic longint atan_entry(input int i);
        longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                            33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                            524287, 262143, 131071, 65535, 32767, 16383, 8191,
                            4095, 2047, 1023, 511, 255, 127};
        return tbl[i];
    endfunction

    function automatic logic [17:0] round_entry(input longint acc);
        int     sh;
        longint v;
        sh = 60 - FRAC;
        v = (acc + (longint'(1) <<< (sh - 1))) >>> sh;
        if (v > 131071)
            v = 131071;
        if (v < -131072)
            v = -131072;
        return v[17:0];
    endfunction

    function automatic matrix_t rodrigues(input rotvec_t vec);
        longint          p[3];
        longint          u[3];
        longint          k[9];
        longint          kk[9];
        longint unsigned sumsq;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        longint unsigned mag;
        longint          ang;
        longint          cx;
        longint          sy;
        longint          zr;
        longint          dx;
        longint          dy;
        longint          omc;
        longint          prod;
        bit              flip;
        int              a;
        int              b;
        matrix_t         m;
        p[0] = longint'($signed(vec.x));
        p[1] = longint'($signed(vec.y));
        p[2] = longint'($signed(vec.z));
        sumsq = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
        if (sumsq == 0)
        begin
            for (int i = 0; i < 9; i++)
                m[i] = (i % 4 == 0) ? round_entry(longint'(1) <<< 60) : '0;
            return m;
        end
        rem = sumsq << 26;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        for (int i = 0; i < 3; i++)
        begin
            mag = longint'(p[i] < 0 ? -p[i] : p[i]) << 43;
            u[i] = longint'((mag + root / 2) / root);
            if (p[i] < 0)
                u[i] = -u[i];
        end
        // wrap to (-pi, pi], then fold into [-pi/2, pi/2] flipping sin and cos
        ang = longint'((root << 3) % longint'(TWO_PI_Q30));
        if (ang > longint'(PI_Q30))
            ang = ang - longint'(TWO_PI_Q30);
        flip = 0;
        if (ang > longint'(HALF_PI_Q30))
        begin
            ang = ang - longint'(PI_Q30);
            flip = 1;
        end
        else if (ang < -longint'(HALF_PI_Q30))
        begin
            ang = ang + longint'(PI_Q30);
            flip = 1;
        end
        cx = longint'(GAIN_Q30);
        sy = 0;
        zr = ang;
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (zr >= 0)
            begin
                cx = cx - dx;
                sy = sy + dy;
                zr = zr - atan_entry(i);
            end
            else
            begin
                cx = cx + dx;
                sy = sy - dy;
                zr = zr + atan_entry(i);
            end
        end
        if (flip)
        begin
            sy = -sy;
            cx = -cx;
        end
        omc = longint'(ONE_Q30) - cx;
        k = '{0, -u[2], u[1], u[2], 0, -u[0], -u[1], u[0], 0};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                if (i == j)
                begin
                    a = (i + 1) % 3;
                    b = (i + 2) % 3;
                    prod = -(u[a] * u[a] + u[b] * u[b]);
                end
                else
                    prod = u[i] * u[j];
                kk[i * 3 + j] = (prod + (longint'(1) <<< 29)) >>> 30;
            end
        for (int i = 0; i < 9; i++)
            m[i] = round_entry((i % 4 == 0 ? (longint'(1) <<< 60) : 0)
                               + sy * k[i] + omc * kk[i]);
        return m;
    endfunction

    function automatic logic [17:0] rand_comp(input int mode);
        case (mode)
            0: return 18'($urandom);
            1: return 18'($urandom_range(0, 600) - 300);
            2: return 18'($urandom_range(0, 60000) - 30000);
            3: return ($urandom_range(0, 1) != 0) ? 18'h1ffff : 18'h20000;
            default: return '0;
        endcase
    endfunction

    task automatic add_random(input int count);
        rotvec_t v;
        int      mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 9);
            v.x = rand_comp(mode < 5 ? 0 : mode < 7 ? 2 : mode < 8 ? 1 : $urandom_range(0, 4));
            v.y = rand_comp(mode < 5 ? 0 : mode < 7 ? 2 : mode < 8 ? 1 : $urandom_range(0, 4));
            v.z = rand_comp(mode < 5 ? 0 : mode < 7 ? 2 : mode < 8 ? 1 : $urandom_range(0, 4));
            vec_queue.push_back(v);
        end
    endtask

    task automatic wait_drained;
        while (vec_queue.size() != 0 || s_tvalid || matrix_queue.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 0;
        forever
            #5 clk = ~clk;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || in_taken)
        begin
            // in_taken tells whether the word was accepted at the last rising edge
            if (vec_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tvalid <= 1;
                s_tdata  <= {2'b00, vec_queue.pop_front()};
            end
            else
                s_tvalid <= 0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 0;
            recv_hold <= 0;
            hold_done <= 0;
        end
        else if (hold_req && !hold_done)
        begin
            m_tready  <= 0;
            recv_hold <= 399;
            hold_done <= 1;
        end
        else if (recv_hold > 0)
        begin
            m_tready <= 0;
            recv_hold <= recv_hold - 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            matrix_queue.push_back(rodrigues(rotvec_t'(s_tdata[53:0])));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (matrix_queue.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected word %h", m_tdata[161:0]);
            end
            else
            begin
                matrix_t want;
                want = matrix_queue.pop_front();
                for (int i = 0; i < 9; i++)
                    if (want[i] !== m_tdata[i * 18 +: 18])
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("entry %0d: expected %0d got %0d", i,
                                     $signed(want[i]), $signed(m_tdata[i * 18 +: 18]));
                        break;
                    end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rotvec_t v;
        send_idle_pct = 20;
        recv_idle_pct = 57;
        hold_req      = 0;
        rst_n         = 0;
        repeat (4) @(posedge clk);
        rst_n = 1;

        // zero, single axes at both extremes, multiples of pi/2, tiny and full corners, mixed vectors
        vec_queue.push_back('{z: 18'd0, y: 18'd0, x: 18'd0});
        vec_queue.push_back('{z: 18'd0, y: 18'd0, x: 18'h1ffff});
        vec_queue.push_back('{z: 18'd0, y: 18'd0, x: 18'h20000});
        vec_queue.push_back('{z: 18'd0, y: 18'h1ffff, x: 18'd0});
        vec_queue.push_back('{z: 18'd0, y: 18'h20000, x: 18'd0});
        vec_queue.push_back('{z: 18'h1ffff, y: 18'd0, x: 18'd0});
        vec_queue.push_back('{z: 18'h20000, y: 18'd0, x: 18'd0});
        vec_queue.push_back('{z: 18'h1ffff, y: 18'h1ffff, x: 18'h1ffff});
        vec_queue.push_back('{z: 18'h20000, y: 18'h20000, x: 18'h20000});
        vec_queue.push_back('{z: 18'd0, y: 18'd0, x: 18'd1});
        vec_queue.push_back('{z: 18'h3ffff, y: 18'd0, x: 18'd0});
        vec_queue.push_back('{z: 18'd51472, y: 18'd0, x: 18'd0});
        vec_queue.push_back('{z: 18'd0, y: 18'd25736, x: 18'd0});
        vec_queue.push_back('{z: 18'd0, y: 18'd0, x: 18'd102944});
        vec_queue.push_back('{z: -18'sd25736, y: 18'd0, x: 18'd0});
        vec_queue.push_back('{z: 18'd1, y: 18'h3ffff, x: 18'd1});
        vec_queue.push_back('{z: 18'd8000, y: -18'sd12000, x: 18'd30000});
        vec_queue.push_back('{z: 18'h1ffff, y: 18'h20000, x: 18'h2aaaa});
        add_random(280);
        wait_drained;

        send_idle_pct = 57;
        recv_idle_pct = 20;
        add_random(300);
        wait_drained;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        hold_req = 1;
        add_random(300);
        wait_drained;

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && matrix_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/rv2m_pkg.sv
sv/rotation_vector_to_matrix_top.sv
verif/tb_rotation_vector_to_matrix_top.sv
